// ----- sv/plsc_pkg.sv -----
// shared types and constants of the packet link statistics block
`timescale 1ns / 1ps
`default_nettype none

package plsc_pkg;

  // field widths
  localparam int MODE_W  = 2;
  localparam int LEN_W   = 9;
  localparam int BYTE_W  = 8;
  localparam int SEQ_W   = 16;
  localparam int RSSI_W  = 9;
  localparam int TIME_W  = 32;
  localparam int CNT_W   = 32;
  localparam int SUM_W   = 42;

  // one quotient bit per divider step over the whole running sum
  localparam int DIV_STEPS = SUM_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // largest average magnitude: all packets at the most negative rssi
  localparam int RSSI_MAG_MAX = 256;

  // default receive buffer size in bytes
  localparam int BUFFER_BYTES_DEF = 256;

  // event kinds
  typedef enum logic [MODE_W-1:0] {
    MODE_GOOD  = 2'd0,
    MODE_CRC   = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

endpackage

`default_nettype wire

// ----- sv/plsc_if.sv -----
// valid/ready channels for receive events and statistics items
`timescale 1ns / 1ps
`default_nettype none

interface plsc_in_if
  import plsc_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic [LEN_W-1:0]         packet_length;
  logic [BYTE_W-1:0]        seq_low_byte;
  logic [BYTE_W-1:0]        seq_high_byte;
  logic signed [RSSI_W-1:0] rssi_dbm;
  logic [TIME_W-1:0]        now_ms;

  modport source (output valid, mode, packet_length, seq_low_byte, seq_high_byte,
                  rssi_dbm, now_ms, input ready);
  modport sink   (input valid, mode, packet_length, seq_low_byte, seq_high_byte,
                  rssi_dbm, now_ms, output ready);
endinterface

interface plsc_out_if
  import plsc_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     packet_accepted;
  logic [SEQ_W-1:0]         echo_seq;
  logic signed [RSSI_W-1:0] echo_rssi;
  logic [TIME_W-1:0]        delta_ms;
  logic [LEN_W-1:0]         echo_length;
  logic [CNT_W-1:0]         received_total;
  logic [CNT_W-1:0]         lost_total;
  logic [CNT_W-1:0]         crc_error_total;
  logic signed [RSSI_W-1:0] rssi_minimum;
  logic signed [RSSI_W-1:0] rssi_average;
  logic signed [RSSI_W-1:0] rssi_maximum;

  modport source (output valid, packet_accepted, echo_seq, echo_rssi, delta_ms,
                  echo_length, received_total, lost_total, crc_error_total,
                  rssi_minimum, rssi_average, rssi_maximum, input ready);
  modport sink   (input valid, packet_accepted, echo_seq, echo_rssi, delta_ms,
                  echo_length, received_total, lost_total, crc_error_total,
                  rssi_minimum, rssi_average, rssi_maximum, output ready);
endinterface

`default_nettype wire

// ----- sv/packet_link_statistics_core.sv -----
// packet link statistics: counters, rssi tracking and bit-serial average
//
// Usage: in_if carries one receive event per item (good packet, crc/read
// error, or clear statistics). For every accepted item exactly one item
// leaves on out_if, carrying the per-packet echo fields and the statistics
// as they stand after this event. A good packet counts only when its length
// is 1 to BUFFER_BYTES; otherwise nothing changes and it is reported as not
// accepted.
// Sequence: counters update in the accept cycle, the START state loads the
// divider, then a restoring divider shifts the 42-bit running sum through one
// quotient bit per cycle over its 42 steps, and the HOLD state parks the
// result until the output register frees. The 42-step divider sets the rate:
// no new item is taken until the last one has left the divider and HOLD.
// in_if.ready is high only while no item is in the divider.
// Reset (synchronous, rst_n low) zeroes all counters, marks, the running
// sum, the sequence history and the stored packet time, and empties the
// output register.
// A stalled receiver holds the output item; a finished item then waits in
// the core and no new item is taken until the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module packet_link_statistics_core
  import plsc_pkg::*;
#(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  plsc_in_if.sink      in_if,
  plsc_out_if.source   out_if
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_START = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_HOLD  = 4'b1000
  } state_t;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // control and statistics state
  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         rx_cnt_r, rx_cnt_nxt;
  logic [CNT_W-1:0]         crc_cnt_r, crc_cnt_nxt;
  logic [CNT_W-1:0]         lost_cnt_r, lost_cnt_nxt;
  logic signed [RSSI_W-1:0] low_r, low_nxt;
  logic signed [RSSI_W-1:0] high_r, high_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SEQ_W-1:0]         prev_seq_r, prev_seq_nxt;
  logic                     prev_valid_r, prev_valid_nxt;
  logic [TIME_W-1:0]        last_time_r, last_time_nxt;
  logic [STEP_W-1:0]        bit_cnt_r, bit_cnt_nxt;
  logic                     out_valid_r, out_valid_nxt;

  // divider datapath and pending echo fields
  logic [CNT_W-1:0]         rem_r, rem_nxt;
  logic [SUM_W-1:0]         quo_r, quo_nxt;
  logic [CNT_W-1:0]         dvs_r, dvs_nxt;
  logic                     neg_r, neg_nxt;
  logic signed [RSSI_W-1:0] avg_r, avg_nxt;
  logic                     res_acc_r, res_acc_nxt;
  logic [SEQ_W-1:0]         res_seq_r, res_seq_nxt;
  logic signed [RSSI_W-1:0] res_rssi_r, res_rssi_nxt;
  logic [TIME_W-1:0]        res_delta_r, res_delta_nxt;
  logic [LEN_W-1:0]         res_len_r, res_len_nxt;

  // output register
  logic                     o_acc_r;
  logic [SEQ_W-1:0]         o_seq_r;
  logic signed [RSSI_W-1:0] o_rssi_r;
  logic [TIME_W-1:0]        o_delta_r;
  logic [LEN_W-1:0]         o_len_r;
  logic [CNT_W-1:0]         o_rx_r, o_lost_r, o_crc_r;
  logic signed [RSSI_W-1:0] o_low_r, o_avg_r, o_high_r;

  // event decode
  logic                     in_fire;
  logic                     pkt_ok;
  logic                     seq_present;
  logic [SEQ_W-1:0]         seq;
  logic [SEQ_W-1:0]         gap;
  logic [CNT_W:0]           lost_sum;
  logic                     out_free;
  logic                     load_out;

  // divider step
  logic [SUM_W-1:0]         sum_mag;
  logic [CNT_W:0]           div_shift;
  logic [CNT_W+1:0]         div_diff;
  logic [SUM_W-1:0]         quo_step;
  logic [CNT_W-1:0]         rem_step;
  logic [RSSI_W-1:0]        q_low;

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_r || out_if.ready;
  assign load_out    = (state_r == ST_HOLD) && out_free;

  // good packet with a usable length
  assign pkt_ok      = (mode_t'(in_if.mode) == MODE_GOOD) && (in_if.packet_length != '0)
                    && (32'(in_if.packet_length) <= BUFFER_BYTES);
  assign seq_present = (in_if.packet_length >= LEN_W'(2));
  assign seq         = seq_present ? {in_if.seq_high_byte, in_if.seq_low_byte} : '0;
  assign gap         = seq - prev_seq_r - SEQ_W'(1);
  assign lost_sum    = {1'b0, lost_cnt_r} + (CNT_W + 1)'(gap);

  // one restoring division step
  assign sum_mag   = sum_r[SUM_W-1] ? $unsigned(-sum_r) : $unsigned(sum_r);
  assign div_shift = {rem_r, quo_r[SUM_W-1]};
  assign div_diff  = {1'b0, div_shift} - {2'b00, dvs_r};
  assign rem_step  = div_diff[CNT_W+1] ? div_shift[CNT_W-1:0] : div_diff[CNT_W-1:0];
  assign quo_step  = {quo_r[SUM_W-2:0], !div_diff[CNT_W+1]};
  assign q_low     = quo_step[RSSI_W-1:0];

  // next-state logic
  always_comb begin
    state_nxt      = state_r;
    rx_cnt_nxt     = rx_cnt_r;
    crc_cnt_nxt    = crc_cnt_r;
    lost_cnt_nxt   = lost_cnt_r;
    low_nxt        = low_r;
    high_nxt       = high_r;
    sum_nxt        = sum_r;
    prev_seq_nxt   = prev_seq_r;
    prev_valid_nxt = prev_valid_r;
    last_time_nxt  = last_time_r;
    bit_cnt_nxt    = bit_cnt_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    dvs_nxt        = dvs_r;
    neg_nxt        = neg_r;
    avg_nxt        = avg_r;
    res_acc_nxt    = res_acc_r;
    res_seq_nxt    = res_seq_r;
    res_rssi_nxt   = res_rssi_r;
    res_delta_nxt  = res_delta_r;
    res_len_nxt    = res_len_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          res_acc_nxt   = 1'b0;
          res_seq_nxt   = '0;
          res_rssi_nxt  = '0;
          res_delta_nxt = '0;
          res_len_nxt   = '0;
          if (pkt_ok) begin
            // statistics update for an accepted packet
            res_acc_nxt   = 1'b1;
            res_seq_nxt   = seq;
            res_rssi_nxt  = in_if.rssi_dbm;
            res_len_nxt   = in_if.packet_length;
            res_delta_nxt = (last_time_r != '0) ? (in_if.now_ms - last_time_r) : '0;
            last_time_nxt = in_if.now_ms;
            if ((rx_cnt_r == '0) || (in_if.rssi_dbm < low_r)) begin
              low_nxt = in_if.rssi_dbm;
            end
            if ((rx_cnt_r == '0) || (in_if.rssi_dbm > high_r)) begin
              high_nxt = in_if.rssi_dbm;
            end
            if (rx_cnt_r != CNT_MAX) begin
              rx_cnt_nxt = rx_cnt_r + CNT_W'(1);
              sum_nxt    = sum_r + SUM_W'(in_if.rssi_dbm);
            end
            if (seq_present) begin
              if (prev_valid_r && (seq > prev_seq_r)) begin
                lost_cnt_nxt = lost_sum[CNT_W] ? CNT_MAX : lost_sum[CNT_W-1:0];
              end
              prev_seq_nxt   = seq;
              prev_valid_nxt = 1'b1;
            end
          end else if (mode_t'(in_if.mode) == MODE_CRC) begin
            crc_cnt_nxt = (crc_cnt_r == CNT_MAX) ? crc_cnt_r : crc_cnt_r + CNT_W'(1);
          end else if (mode_t'(in_if.mode) == MODE_CLEAR) begin
            rx_cnt_nxt     = '0;
            crc_cnt_nxt    = '0;
            lost_cnt_nxt   = '0;
            low_nxt        = '0;
            high_nxt       = '0;
            sum_nxt        = '0;
            prev_seq_nxt   = '0;
            prev_valid_nxt = 1'b0;
          end
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        // load |sum| / count into the divider
        rem_nxt     = '0;
        quo_nxt     = sum_mag;
        dvs_nxt     = rx_cnt_r;
        neg_nxt     = sum_r[SUM_W-1];
        bit_cnt_nxt = STEP_W'(DIV_STEPS - 1);
        state_nxt   = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt     = rem_step;
        quo_nxt     = quo_step;
        bit_cnt_nxt = bit_cnt_r - STEP_W'(1);
        if (bit_cnt_r == '0) begin
          if (rx_cnt_r == '0) begin
            avg_nxt = '0;
          end else begin
            avg_nxt = neg_r ? -q_low : q_low;
          end
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // output handshake
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control and statistics registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rx_cnt_r     <= '0;
      crc_cnt_r    <= '0;
      lost_cnt_r   <= '0;
      low_r        <= '0;
      high_r       <= '0;
      sum_r        <= '0;
      prev_seq_r   <= '0;
      prev_valid_r <= 1'b0;
      last_time_r  <= '0;
      bit_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rx_cnt_r     <= rx_cnt_nxt;
      crc_cnt_r    <= crc_cnt_nxt;
      lost_cnt_r   <= lost_cnt_nxt;
      low_r        <= low_nxt;
      high_r       <= high_nxt;
      sum_r        <= sum_nxt;
      prev_seq_r   <= prev_seq_nxt;
      prev_valid_r <= prev_valid_nxt;
      last_time_r  <= last_time_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // divider and result payload registers
  always_ff @(posedge clk) begin
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    dvs_r       <= dvs_nxt;
    neg_r       <= neg_nxt;
    avg_r       <= avg_nxt;
    res_acc_r   <= res_acc_nxt;
    res_seq_r   <= res_seq_nxt;
    res_rssi_r  <= res_rssi_nxt;
    res_delta_r <= res_delta_nxt;
    res_len_r   <= res_len_nxt;
    if (load_out) begin
      o_acc_r   <= res_acc_r;
      o_seq_r   <= res_seq_r;
      o_rssi_r  <= res_rssi_r;
      o_delta_r <= res_delta_r;
      o_len_r   <= res_len_r;
      o_rx_r    <= rx_cnt_r;
      o_lost_r  <= lost_cnt_r;
      o_crc_r   <= crc_cnt_r;
      o_low_r   <= low_r;
      o_avg_r   <= avg_r;
      o_high_r  <= high_r;
    end
  end

  // output item
  assign out_if.valid           = out_valid_r;
  assign out_if.packet_accepted = o_acc_r;
  assign out_if.echo_seq        = o_seq_r;
  assign out_if.echo_rssi       = o_rssi_r;
  assign out_if.delta_ms        = o_delta_r;
  assign out_if.echo_length     = o_len_r;
  assign out_if.received_total  = o_rx_r;
  assign out_if.lost_total      = o_lost_r;
  assign out_if.crc_error_total = o_crc_r;
  assign out_if.rssi_minimum    = o_low_r;
  assign out_if.rssi_average    = o_avg_r;
  assign out_if.rssi_maximum    = o_high_r;

  // an accepted packet always leaves a nonzero packet count
  a_count_after_packet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && pkt_ok) |=> (rx_cnt_r != '0))
    else $error("packet count zero after an accepted packet");

  // marks stay ordered while packets are counted
  a_marks_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (rx_cnt_r != '0) |-> (low_r <= high_r))
    else $error("rssi minimum above maximum");

  // the average magnitude never exceeds the rssi range
  a_quotient_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DIV) && (bit_cnt_r == '0) && (rx_cnt_r != '0))
      |-> (quo_step <= SUM_W'(RSSI_MAG_MAX)))
    else $error("average quotient out of range");

  // the core takes no item while one is in the divider
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_START) && !in_if.ready)
    else $error("item taken while busy");

endmodule

`default_nettype wire
